### sv/blpm_pkg.sv
// blpm_pkg: shared types and constants of the longest prefix match trie.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package blpm_pkg;

	// fixed field widths
	localparam int ADDR_BITS = 32;
	localparam int PLEN_W = 6;
	localparam int IF_W = 8;

	// default size of the node store
	localparam int NODE_COUNT_DEF = 1024;

	// entries of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// one classified request
	typedef struct packed {
		op_t               op;
		logic [ADDR_BITS-1:0] addr;
		logic [PLEN_W-1:0] plen;
		logic [IF_W-1:0]   iface;
	} item_t;

endpackage

### sv/blpm_front.sv
// blpm_front: input stage; decodes the action and clamps the prefix length.
// Depends on blpm_pkg.
`timescale 1ns / 1ps

module blpm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic                              action,
	input  logic [blpm_pkg::ADDR_BITS-1:0]    address,
	input  logic [blpm_pkg::PLEN_W-1:0]       prefix_length,
	input  logic [blpm_pkg::IF_W-1:0]         route_interface,
	output logic                              item_valid,
	input  logic                              item_ready,
	output blpm_pkg::item_t                   item
);

	logic            valid_s1;
	blpm_pkg::item_t item_s1;
	blpm_pkg::item_t item_n;

	// classify and saturate the prefix length
	always_comb begin
		item_n.op    = action ? blpm_pkg::OP_LOOKUP : blpm_pkg::OP_INSERT;
		item_n.addr  = address;
		item_n.iface = route_interface;
		if (prefix_length > blpm_pkg::PLEN_W'(blpm_pkg::ADDR_BITS)) begin
			item_n.plen = blpm_pkg::PLEN_W'(blpm_pkg::ADDR_BITS);
		end else begin
			item_n.plen = prefix_length;
		end
	end

	assign req_ready  = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= item_n;
		end
	end

endmodule

### sv/blpm_queue.sv
// blpm_queue: short FIFO of classified requests between front and back.
// Depends on blpm_pkg.
`timescale 1ns / 1ps

module blpm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  blpm_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output blpm_pkg::item_t pop_item
);

	localparam int PW = (blpm_pkg::QUEUE_DEPTH > 1) ? $clog2(blpm_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(blpm_pkg::QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(blpm_pkg::QUEUE_DEPTH - 1);

	blpm_pkg::item_t entry_q [blpm_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = count_q != CW'(blpm_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### sv/blpm_walk.sv
// blpm_walk: trie walker with the node store and result register; runs inserts
// and lookups, one trie level per cycle unless allocating. Depends on blpm_pkg.
`timescale 1ns / 1ps

module blpm_walk #(
	parameter int NODE_COUNT = blpm_pkg::NODE_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  blpm_pkg::item_t             item,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        found,
	output logic [blpm_pkg::IF_W-1:0]   matched_interface,
	output logic                        status
);

	localparam int NW = $clog2(NODE_COUNT);
	localparam logic [NW:0] NODE_LIMIT = (NW+1)'(NODE_COUNT);
	localparam int AB = blpm_pkg::ADDR_BITS;
	localparam int PW = blpm_pkg::PLEN_W;
	localparam int IW = blpm_pkg::IF_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_ALLOC,
		S_LINK,
		S_DONE
	} state_t;

	state_t            state_q;
	blpm_pkg::op_t     op_q;
	logic [AB-1:0]     addr_q;
	logic [PW-1:0]     plen_q;
	logic [IW-1:0]     iface_q;
	logic [NW-1:0]     node_q;
	logic [PW-1:0]     depth_q;
	logic [NW:0]       nfree_q;
	logic              have_q;
	logic [IW-1:0]     best_q;
	logic              res_found_q;
	logic [IW-1:0]     res_if_q;
	logic              res_status_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [IW-1:0]     out_if_q;
	logic              out_status_q;

	// root node lives in flip-flops so that reset can clear it
	logic [NW-1:0]     root_zero_q;
	logic [NW-1:0]     root_one_q;
	logic              root_has_q;
	logic [IW-1:0]     root_if_q;

	// node store, one array per field
	logic [NW-1:0]     zero_mem [NODE_COUNT];
	logic [NW-1:0]     one_mem  [NODE_COUNT];
	logic              has_mem  [NODE_COUNT];
	logic [IW-1:0]     if_mem   [NODE_COUNT];
	logic [NW-1:0]     rd_zero_q;
	logic [NW-1:0]     rd_one_q;
	logic              rd_has_q;
	logic [IW-1:0]     rd_if_q;

	logic [NW-1:0]     rd_addr;
	logic              zero_we;
	logic              one_we;
	logic              has_we;
	logic              if_we;
	logic [NW-1:0]     zero_wa;
	logic [NW-1:0]     one_wa;
	logic [NW-1:0]     has_wa;
	logic [NW-1:0]     child_wd;
	logic              has_wd;

	logic              at_root;
	logic [NW-1:0]     cur_zero;
	logic [NW-1:0]     cur_one;
	logic              cur_has;
	logic [IW-1:0]     cur_if;
	logic              bit_cur;
	logic [NW-1:0]     next_node;
	logic              have_n;
	logic [IW-1:0]     best_n;
	logic              ins_end;
	logic              look_end;
	logic              out_free;
	logic [NW-1:0]     nfree_idx;

	// current node fields: root from flops, others from the store
	assign at_root   = node_q == '0;
	assign cur_zero  = at_root ? root_zero_q : rd_zero_q;
	assign cur_one   = at_root ? root_one_q  : rd_one_q;
	assign cur_has   = at_root ? root_has_q  : rd_has_q;
	assign cur_if    = at_root ? root_if_q   : rd_if_q;
	assign bit_cur   = addr_q[AB-1];
	assign next_node = bit_cur ? cur_one : cur_zero;
	assign have_n    = have_q || cur_has;
	assign best_n    = cur_has ? cur_if : best_q;
	assign ins_end   = depth_q == plen_q;
	assign look_end  = (depth_q == PW'(AB)) || (next_node == '0);
	assign out_free  = !out_valid_q || res_ready;
	assign nfree_idx = nfree_q[NW-1:0];

	assign item_ready        = state_q == S_IDLE;
	assign res_valid         = out_valid_q;
	assign found             = out_found_q;
	assign matched_interface = out_if_q;
	assign status            = out_status_q;

	// store read address and write ports
	always_comb begin
		rd_addr  = next_node;
		zero_we  = 1'b0;
		one_we   = 1'b0;
		has_we   = 1'b0;
		if_we    = 1'b0;
		zero_wa  = nfree_idx;
		one_wa   = nfree_idx;
		has_wa   = nfree_idx;
		child_wd = '0;
		has_wd   = 1'b0;
		unique case (state_q)
			S_EVAL: begin
				// insert reaches its final node: set the route
				if (op_q == blpm_pkg::OP_INSERT && ins_end && !at_root) begin
					has_we = 1'b1;
					if_we  = 1'b1;
					has_wa = node_q;
					has_wd = 1'b1;
				end
			end
			S_ALLOC: begin
				// clear the new node
				zero_we = 1'b1;
				one_we  = 1'b1;
				has_we  = 1'b1;
			end
			S_LINK: begin
				// hook the new node under its parent, then read it
				rd_addr  = nfree_idx;
				child_wd = nfree_idx;
				if (!at_root) begin
					if (bit_cur) begin
						one_we = 1'b1;
						one_wa = node_q;
					end else begin
						zero_we = 1'b1;
						zero_wa = node_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// node store arrays
	always_ff @(posedge clk) begin
		if (zero_we) begin
			zero_mem[zero_wa] <= child_wd;
		end
		rd_zero_q <= zero_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (one_we) begin
			one_mem[one_wa] <= child_wd;
		end
		rd_one_q <= one_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (has_we) begin
			has_mem[has_wa] <= has_wd;
		end
		rd_has_q <= has_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (if_we) begin
			if_mem[node_q] <= iface_q;
		end
		rd_if_q <= if_mem[rd_addr];
	end

	// walk sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nfree_q     <= (NW+1)'(1);
			root_zero_q <= '0;
			root_one_q  <= '0;
			root_has_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result taken; in S_DONE the valid is reloaded below
			if (res_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						op_q    <= item.op;
						addr_q  <= item.addr;
						plen_q  <= item.plen;
						iface_q <= item.iface;
						node_q  <= '0;
						depth_q <= '0;
						have_q  <= 1'b0;
						best_q  <= '0;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (op_q == blpm_pkg::OP_LOOKUP) begin
						have_q <= have_n;
						best_q <= best_n;
						if (look_end) begin
							res_found_q  <= have_n;
							res_if_q     <= have_n ? best_n : '0;
							res_status_q <= 1'b0;
							state_q      <= S_DONE;
						end else begin
							node_q  <= next_node;
							depth_q <= PW'(depth_q + 1'b1);
							addr_q  <= addr_q << 1;
						end
					end else if (ins_end) begin
						if (at_root) begin
							root_has_q <= 1'b1;
							root_if_q  <= iface_q;
						end
						res_found_q  <= 1'b0;
						res_if_q     <= '0;
						res_status_q <= 1'b0;
						state_q      <= S_DONE;
					end else if (next_node != '0) begin
						node_q  <= next_node;
						depth_q <= PW'(depth_q + 1'b1);
						addr_q  <= addr_q << 1;
					end else if (nfree_q == NODE_LIMIT) begin
						// store full: stop the insert
						res_found_q  <= 1'b0;
						res_if_q     <= '0;
						res_status_q <= 1'b1;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					if (at_root) begin
						if (bit_cur) begin
							root_one_q <= nfree_idx;
						end else begin
							root_zero_q <= nfree_idx;
						end
					end
					node_q  <= nfree_idx;
					nfree_q <= (NW+1)'(nfree_q + 1'b1);
					depth_q <= PW'(depth_q + 1'b1);
					addr_q  <= addr_q << 1;
					state_q <= S_EVAL;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_found_q  <= res_found_q;
						out_if_q     <= res_if_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/binary_trie_longest_prefix_match.sv
// binary_trie_longest_prefix_match: top level of the IPv4 route trie.
// Instantiates blpm_front, blpm_queue and blpm_walk; depends on blpm_pkg.
//
// Request channel (req_valid/req_ready): action 0 inserts the route
// address/prefix_length with route_interface, action 1 looks up address.
// Prefix lengths above 32 are treated as 32. Result channel
// (res_valid/res_ready) returns one result per request in order: found and
// matched_interface for lookups, status 1 when an insert ran out of nodes.
// A request passes an input stage and a two-entry queue, then the walker
// takes it: it starts the walk, visits the trie levels one by one (up to 33
// levels for a lookup), passes the allocate and link states for each node an
// insert allocates, and then posts the result. The walk is bound by the
// dependent node-store read of each level. Reset clears the root node and
// the free pointer at once; no clearing pass is needed. While res_ready is
// low the finished result is held, the walker waits after one further
// result, and the queue keeps accepting requests until full.
`timescale 1ns / 1ps

module binary_trie_longest_prefix_match #(
	parameter int NODE_COUNT = blpm_pkg::NODE_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic                              action,
	input  logic [blpm_pkg::ADDR_BITS-1:0]    address,
	input  logic [blpm_pkg::PLEN_W-1:0]       prefix_length,
	input  logic [blpm_pkg::IF_W-1:0]         route_interface,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic                              found,
	output logic [blpm_pkg::IF_W-1:0]         matched_interface,
	output logic                              status
);

	logic            front_valid;
	logic            front_ready;
	blpm_pkg::item_t front_item;
	logic            walk_valid;
	logic            walk_ready;
	blpm_pkg::item_t walk_item;

	// accept and classify
	blpm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.action          (action),
		.address         (address),
		.prefix_length   (prefix_length),
		.route_interface (route_interface),
		.item_valid      (front_valid),
		.item_ready      (front_ready),
		.item            (front_item)
	);

	// decoupling queue
	blpm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (walk_valid),
		.pop_ready  (walk_ready),
		.pop_item   (walk_item)
	);

	// trie walker and node store
	blpm_walk #(
		.NODE_COUNT (NODE_COUNT)
	) u_walk (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (walk_valid),
		.item_ready        (walk_ready),
		.item              (walk_item),
		.res_valid         (res_valid),
		.res_ready         (res_ready),
		.found             (found),
		.matched_interface (matched_interface),
		.status            (status)
	);

endmodule
